[hdl/assert_macros.svh]
// Assertion macros shared by the RTL.
// Expects signals clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/pvp_pkg.sv]
// Shared types and constants of the point view projection pipeline.
// No dependencies.
package pvp_pkg;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_PROJECT = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	localparam int SIZE_W = 15;
	localparam logic [SIZE_W-1:0] RESET_WIDTH  = 15'd1920;
	localparam logic [SIZE_W-1:0] RESET_HEIGHT = 15'd1080;

	localparam int IDX_W    = 5;
	localparam int FIELD_W  = 32;
	localparam int ACC_W    = 64;
	localparam logic [ACC_W-1:0] PROD_CAP = 64'h4000_0000_0000_0000;

	localparam int NDC_SHIFT = 49;
	localparam int NDC_W     = NDC_SHIFT + 1;
	localparam logic [NDC_W-1:0] NDC_CAP = 50'h2_0000_0000_0000;

	typedef struct packed {
		logic vld;
		logic proj;
		logic ok;
	} ctl_t;

	typedef struct packed {
		ctl_t ctl;
		logic neg_x;
		logic neg_y;
		logic cap_x;
		logic cap_y;
	} side_t;

endpackage

[hdl/pvp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor(num * 2^FRAC_BITS / den); no package dependency.
module pvp_div #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [COORD_WIDTH-1:0]           num,
	input  logic [COORD_WIDTH-1:0]           den,
	output logic [COORD_WIDTH+FRAC_BITS-1:0] quo
);
	localparam int CW = COORD_WIDTH;
	localparam int QW = COORD_WIDTH + FRAC_BITS;

	logic [CW-1:0] rem_q [QW];
	logic [CW-1:0] den_q [QW];
	logic [QW-1:0] dnd_q [QW];
	logic [QW-1:0] quo_q [QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [CW-1:0] rem_i;
		logic [CW-1:0] den_i;
		logic [QW-1:0] dnd_i;
		logic [QW-1:0] quo_i;
		logic [CW:0]   trial;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_i = '0;
			assign den_i = den;
			assign dnd_i = {num, {FRAC_BITS{1'b0}}};
			assign quo_i = '0;
		end else begin : g_next
			assign rem_i = rem_q[i-1];
			assign den_i = den_q[i-1];
			assign dnd_i = dnd_q[i-1];
			assign quo_i = quo_q[i-1];
		end

		assign trial = {rem_i, dnd_i[QW-1]};
		assign take  = trial >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= take ? CW'(trial - {1'b0, den_i}) : trial[CW-1:0];
				den_q[i] <= den_i;
				dnd_q[i] <= dnd_i << 1;
				quo_q[i] <= {quo_i[QW-2:0], take};
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

[hdl/pvp_xform.sv]
// Four-stage 4x4 matrix times vector unit with its own 16-word matrix store.
// Depends on pvp_pkg.
module pvp_xform #(
	parameter int   COORD_WIDTH = 32,
	parameter int   FRAC_BITS   = 16,
	parameter logic BANK        = 1'b0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  pvp_pkg::ctl_t               ctl_i,
	input  logic [pvp_pkg::IDX_W-1:0]   idx_i,
	input  logic [COORD_WIDTH-1:0]      val_i,
	input  logic [3:0][COORD_WIDTH-1:0] vec_i,
	output pvp_pkg::ctl_t               ctl_o,
	output logic [pvp_pkg::IDX_W-1:0]   idx_o,
	output logic [COORD_WIDTH-1:0]      val_o,
	output logic [3:0][COORD_WIDTH-1:0] vec_o
);
	import pvp_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * COORD_WIDTH;

	function automatic logic [ACC_W-1:0] sadd(input logic [ACC_W-1:0] a,
		input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

	logic [15:0][CW-1:0] mat_q;

	logic [15:0][PW-1:0] prod_s1;
	logic [15:0]         neg_s1;
	ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [IDX_W-1:0]    idx_s1, idx_s2, idx_s3, idx_s4;
	logic [CW-1:0]       val_s1, val_s2, val_s3, val_s4;
	logic [3:0][ACC_W-1:0] s2_s2, p2_s2, p3_s2, s3_s3, p3_s3;
	logic [3:0][CW-1:0]  vec_s4;

	logic [15:0][PW-1:0]   prod_d;
	logic [15:0]           neg_d;
	logic [15:0][ACC_W-1:0] pq;
	logic [PW+ACC_W-1:0]   ext;
	logic [ACC_W-1:0]      mg;
	logic [CW-1:0]         ma, mb;
	logic [3:0][ACC_W-1:0] s4;
	logic [3:0]            fit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (en && ctl_i.vld && ctl_i.proj == CMD_LOAD && idx_i[IDX_W-1] == BANK) begin
			mat_q[idx_i[IDX_W-2:0]] <= val_i;
		end
	end

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			ma = mat_q[k][CW-1] ? CW'(-mat_q[k]) : mat_q[k];
			mb = vec_i[k/4][CW-1] ? CW'(-vec_i[k/4]) : vec_i[k/4];
			prod_d[k] = PW'(ma) * PW'(mb);
			neg_d[k] = mat_q[k][CW-1] ^ vec_i[k/4][CW-1];
		end
	end

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			ext = (PW+ACC_W)'(prod_s1[k] >> FRAC_BITS);
			mg = (ext > (PW+ACC_W)'(PROD_CAP)) ? PROD_CAP : ext[ACC_W-1:0];
			pq[k] = neg_s1[k] ? -mg : mg;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			s4[r] = sadd(s3_s3[r], p3_s3[r]);
			fit[r] = (&s4[r][ACC_W-1:CW-1]) || !(|s4[r][ACC_W-1:CW-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= '{vld: ctl_s3.vld, proj: ctl_s3.proj, ok: ctl_s3.ok && (&fit)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_d;
			neg_s1  <= neg_d;
			idx_s1  <= idx_i;
			val_s1  <= val_i;
			idx_s2  <= idx_s1;
			val_s2  <= val_s1;
			idx_s3  <= idx_s2;
			val_s3  <= val_s2;
			idx_s4  <= idx_s3;
			val_s4  <= val_s3;
			for (int r = 0; r < 4; r++) begin
				s2_s2[r]  <= sadd(pq[r], pq[4+r]);
				p2_s2[r]  <= pq[8+r];
				p3_s2[r]  <= pq[12+r];
				s3_s3[r]  <= sadd(s2_s2[r], p2_s2[r]);
				p3_s3[r]  <= p3_s2[r];
				vec_s4[r] <= s4[r][CW-1:0];
			end
		end
	end

	assign ctl_o = ctl_s4;
	assign idx_o = idx_s4;
	assign val_o = val_s4;
	assign vec_o = vec_s4;

endmodule

[hdl/point_view_projection.sv]
// Top level of the point view projection pipeline.
// Depends on pvp_pkg, pvp_xform, pvp_div and assert_macros.svh.
//
// Input channel (in_valid/in_ready): cmd selects a matrix word load
// (entry_index, entry_value) or a point projection (point_x/y/z).
// Output channel (out_valid/out_ready): one transaction per projection,
// visible plus screen_x/screen_y in Q16.16 pixels, zeros when rejected.
// Loads give no output transaction.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 is display width,
// 1 is display height; always ready, write only while the pipe is empty.
// Pipe order: input register, two four-stage matrix units, clip-check register,
// the one-bit-per-stage divider, registers s11 and s12, then the output register.
// Throughput: one transaction per cycle while the receiver does not stall.
// Loads update the matrix store as they pass each matrix unit, so a
// projection sees exactly the loads accepted before it.
// Reset clears both matrices, sets width 1920 and height 1080, empties pipe.
// A stalled receiver freezes the whole pipe and drops in_ready.
module point_view_projection #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [pvp_pkg::IDX_W-1:0]           entry_index,
	input  logic signed [pvp_pkg::FIELD_W-1:0]  entry_value,
	input  logic signed [pvp_pkg::FIELD_W-1:0]  point_x,
	input  logic signed [pvp_pkg::FIELD_W-1:0]  point_y,
	input  logic signed [pvp_pkg::FIELD_W-1:0]  point_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                visible,
	output logic signed [pvp_pkg::FIELD_W-1:0]  screen_x,
	output logic signed [pvp_pkg::FIELD_W-1:0]  screen_y,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pvp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pvp_pkg::SIZE_W-1:0]          cfg_data
);
	import pvp_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int QW = COORD_WIDTH + FRAC_BITS;
	localparam int SW = NDC_W + 2;
	localparam int MW = SW + SIZE_W - 1;
	localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
	localparam logic [MW-1:0] LIM_NEG = MW'(1) << (CW - 1);
	localparam logic [MW-1:0] LIM_POS = LIM_NEG - MW'(1);

	logic en;
	logic [SIZE_W-1:0] width_q, height_q;

	ctl_t               ctl_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [CW-1:0]      val_s1;
	logic [3:0][CW-1:0] pt_s1;

	ctl_t               ctl_v, ctl_c;
	logic [IDX_W-1:0]   idx_v, idx_c;
	logic [CW-1:0]      val_v, val_c;
	logic [3:0][CW-1:0] cam, clip;

	ctl_t          ctl_s10;
	logic [CW-1:0] ux_s10, uy_s10, uw_s10;
	logic          negx_s10, negy_s10, capx_s10, capy_s10;

	logic [CW-1:0] cx, cy, cz, cw, ux, uy;
	logic [CW:0]   zsum;
	logic          w_ok, z_ok;

	logic [QW-1:0] quo_x, quo_y;
	side_t         side_q [QW];
	side_t         side_o;

	logic [NDC_W-1:0] qx, qy;
	logic [SW-1:0]    nx, ny, sx, sy;

	ctl_t          ctl_s11, ctl_s12;
	logic [SW-1:0] sxm_s11, sym_s11;
	logic          sxn_s11, syn_s11, sxn_s12, syn_s12;
	logic [MW-1:0] mx_s12, my_s12;
	logic [SW+SIZE_W-1:0] px, py;
	logic [MW-1:0] vx, vy;
	logic          fx, fy;

	logic                     out_valid_q, visible_q;
	logic [FIELD_W-1:0]       screen_x_q, screen_y_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: in_valid, proj: cmd == CMD_PROJECT, ok: 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1   <= entry_index;
			val_s1   <= CW'(entry_value);
			pt_s1[0] <= CW'(point_x);
			pt_s1[1] <= CW'(point_y);
			pt_s1[2] <= CW'(point_z);
			pt_s1[3] <= ONE_C;
		end
	end

	pvp_xform #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .BANK(1'b0)) u_view (
		.clk, .arst_n, .en,
		.ctl_i(ctl_s1), .idx_i(idx_s1), .val_i(val_s1), .vec_i(pt_s1),
		.ctl_o(ctl_v), .idx_o(idx_v), .val_o(val_v), .vec_o(cam)
	);

	pvp_xform #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .BANK(1'b1)) u_proj (
		.clk, .arst_n, .en,
		.ctl_i(ctl_v), .idx_i(idx_v), .val_i(val_v), .vec_i(cam),
		.ctl_o(ctl_c), .idx_o(idx_c), .val_o(val_c), .vec_o(clip)
	);

	always_comb begin
		cx   = clip[0];
		cy   = clip[1];
		cz   = clip[2];
		cw   = clip[3];
		w_ok = !cw[CW-1] && (cw > CW'(1));
		zsum = {cz[CW-1], cz} + {cw[CW-1], cw};
		z_ok = !zsum[CW];
		ux   = cx[CW-1] ? CW'(-cx) : cx;
		uy   = cy[CW-1] ? CW'(-cy) : cy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s10 <= '0;
		end else if (en) begin
			ctl_s10 <= '{vld: ctl_c.vld, proj: ctl_c.proj, ok: ctl_c.ok && w_ok && z_ok};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s10   <= ux;
			uy_s10   <= uy;
			uw_s10   <= cw;
			negx_s10 <= cx[CW-1];
			negy_s10 <= cy[CW-1];
			capx_s10 <= (CW+NDC_W)'(ux) >= ((CW+NDC_W)'(cw) << (NDC_SHIFT - FRAC_BITS));
			capy_s10 <= (CW+NDC_W)'(uy) >= ((CW+NDC_W)'(cw) << (NDC_SHIFT - FRAC_BITS));
		end
	end

	pvp_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk, .en, .num(ux_s10), .den(uw_s10), .quo(quo_x)
	);

	pvp_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk, .en, .num(uy_s10), .den(uw_s10), .quo(quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++)
				side_q[i] <= '0;
		end else if (en) begin
			side_q[0] <= '{ctl: ctl_s10, neg_x: negx_s10, neg_y: negy_s10,
				cap_x: capx_s10, cap_y: capy_s10};
			for (int i = 1; i < QW; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	assign side_o = side_q[QW-1];

	always_comb begin
		qx = side_o.cap_x ? NDC_CAP : NDC_W'(quo_x);
		qy = side_o.cap_y ? NDC_CAP : NDC_W'(quo_y);
		nx = side_o.neg_x ? -SW'(qx) : SW'(qx);
		ny = side_o.neg_y ? -SW'(qy) : SW'(qy);
		sx = nx + ONE_S;
		sy = ONE_S - ny;
		px = (SW+SIZE_W)'(sxm_s11) * (SW+SIZE_W)'(width_q);
		py = (SW+SIZE_W)'(sym_s11) * (SW+SIZE_W)'(height_q);
		vx = sxn_s12 ? -mx_s12 : mx_s12;
		vy = syn_s12 ? -my_s12 : my_s12;
		fx = mx_s12 <= (sxn_s12 ? LIM_NEG : LIM_POS);
		fy = my_s12 <= (syn_s12 ? LIM_NEG : LIM_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s11     <= '0;
			ctl_s12     <= '0;
			out_valid_q <= 1'b0;
			visible_q   <= 1'b0;
		end else if (en) begin
			ctl_s11     <= side_o.ctl;
			ctl_s12     <= ctl_s11;
			out_valid_q <= ctl_s12.vld && ctl_s12.proj == CMD_PROJECT;
			visible_q   <= ctl_s12.ok && fx && fy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sxn_s11    <= sx[SW-1];
			syn_s11    <= sy[SW-1];
			sxm_s11    <= sx[SW-1] ? -sx : sx;
			sym_s11    <= sy[SW-1] ? -sy : sy;
			sxn_s12    <= sxn_s11;
			syn_s12    <= syn_s11;
			mx_s12     <= px[SW+SIZE_W-1:1];
			my_s12     <= py[SW+SIZE_W-1:1];
			screen_x_q <= (ctl_s12.ok && fx && fy) ? vx[FIELD_W-1:0] : '0;
			screen_y_q <= (ctl_s12.ok && fx && fy) ? vy[FIELD_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;
	assign screen_x  = screen_x_q;
	assign screen_y  = screen_y_q;

	`include "assert_macros.svh"

	`ASSERT_AT(a_hidden_zero, out_valid && !visible |-> screen_x == '0 && screen_y == '0, "hidden point with nonzero position")
	`ASSERT_NEXT(a_stall_freeze, out_valid && !out_ready, $stable(ctl_s10) && $stable(ctl_s12), "pipe advanced during output stall")
	`ASSERT_NEXT(a_load_silent, ctl_s12.vld && ctl_s12.proj == CMD_LOAD && en, !out_valid, "load produced an output transaction")

endmodule

[verif/point_view_projection_tb.sv]
// Self-checking testbench of point_view_projection: loads matrix words, projects
// points under several screen sizes and checks every result against a predictor.
// Depends on pvp_pkg and the point_view_projection RTL.
module point_view_projection_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pvp_pkg::*;

	localparam int LATENCY    = 61;
	localparam int IDLE_LIMIT = 4000;
	localparam longint ONE    = 64'sd65536;

	typedef struct packed {
		logic cmd;
		logic [IDX_W-1:0] idx;
		logic signed [FIELD_W-1:0] val;
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		logic signed [FIELD_W-1:0] z;
	} xact_t;

	typedef struct packed {
		logic visible;
		logic signed [FIELD_W-1:0] sx;
		logic signed [FIELD_W-1:0] sy;
	} screen_t;

	class projection_scoreboard;
		logic signed [FIELD_W-1:0] matrix[32];
		logic [SIZE_W-1:0] width_px;
		logic [SIZE_W-1:0] height_px;
		screen_t pending[$];
		int errors;

		function new();
			foreach (matrix[i]) matrix[i] = '0;
			width_px = RESET_WIDTH;
			height_px = RESET_HEIGHT;
			errors = 0;
		endfunction

		function void set_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
			if (idx == CFG_WIDTH) width_px = data;
			else if (idx == CFG_HEIGHT) height_px = data;
		endfunction

		function bit in_range(longint v);
			return v >= -(64'sd1 <<< 31) && v <= (64'sd1 <<< 31) - 1;
		endfunction

		function longint mul_q(longint a, longint b);
			longint unsigned ua, ub, r;
			ua = a < 0 ? -a : a;
			ub = b < 0 ? -b : b;
			r = (ua * ub) >> 16;
			if (r > (64'd1 << 62)) r = 64'd1 << 62;
			return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
		endfunction

		function bit mat_vec(int base, longint v[4], output longint o[4]);
			bit ok;
			ok = 1;
			for (int r = 0; r < 4; r++) begin
				o[r] = 0;
				for (int c = 0; c < 4; c++)
					o[r] += mul_q(longint'(matrix[base + c * 4 + r]), v[c]);
				if (!in_range(o[r])) ok = 0;
			end
			return ok;
		endfunction

		function longint div_q(longint c, longint w);
			longint unsigned uc, q;
			uc = c < 0 ? -c : c;
			q = (uc << 16) / longint'(w);
			if (q > (64'd1 << 49)) q = 64'd1 << 49;
			return c < 0 ? -longint'(q) : longint'(q);
		endfunction

		function longint to_pixels(longint s, logic [SIZE_W-1:0] size);
			logic [127:0] m;
			m = (128'(s < 0 ? -s : s) * 128'(size)) >> 1;
			if (m > (128'd1 << 62)) m = 128'd1 << 62;
			return s < 0 ? -longint'(m[63:0]) : longint'(m[63:0]);
		endfunction

		function screen_t project(xact_t t);
			longint pt[4], cam[4], clip[4];
			longint sx, sy;
			screen_t res;
			res = '0;
			pt[0] = t.x;
			pt[1] = t.y;
			pt[2] = t.z;
			pt[3] = ONE;
			if (!mat_vec(0, pt, cam)) return res;
			if (!mat_vec(16, cam, clip)) return res;
			if (clip[3] <= 1 || clip[2] < -clip[3]) return res;
			sx = to_pixels(div_q(clip[0], clip[3]) + ONE, width_px);
			sy = to_pixels(ONE - div_q(clip[1], clip[3]), height_px);
			if (!in_range(sx) || !in_range(sy)) return res;
			res.visible = 1;
			res.sx = sx[31:0];
			res.sy = sy[31:0];
			return res;
		endfunction

		function void note_input(xact_t t);
			if (t.cmd == CMD_LOAD) matrix[t.idx] = t.val;
			else pending.push_back(project(t));
		endfunction

		function void check_result(screen_t got);
			screen_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result vis=%0b x=%0d y=%0d", $time,
					got.visible, got.sx, got.sy);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.visible !== exp_r.visible) begin
				$display("%0t: visible expected %0b actual %0b", $time, exp_r.visible, got.visible);
				errors++;
			end
			if (got.sx !== exp_r.sx) begin
				$display("%0t: screen_x expected %0d actual %0d", $time, exp_r.sx, got.sx);
				errors++;
			end
			if (got.sy !== exp_r.sy) begin
				$display("%0t: screen_y expected %0d actual %0d", $time, exp_r.sy, got.sy);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, cmd;
	logic [IDX_W-1:0] entry_index;
	logic signed [FIELD_W-1:0] entry_value, point_x, point_y, point_z;
	logic out_valid, out_ready, visible;
	logic signed [FIELD_W-1:0] screen_x, screen_y;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIZE_W-1:0] cfg_data;

	projection_scoreboard sb = new();
	int idle_cycles = 0;
	bit stall_out = 1;

	point_view_projection u_dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (!arst_n || !stall_out) out_ready <= 1;
		else out_ready <= pick_gap() == 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input({cmd, entry_index, entry_value, point_x, point_y, point_z});
			if (out_valid && out_ready) sb.check_result({visible, screen_x, screen_y});
			if (cfg_valid && cfg_ready) sb.set_size(cfg_index, cfg_data);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send(xact_t t, bit use_gaps);
		int gap;
		in_valid <= 1;
		cmd <= t.cmd;
		entry_index <= t.idx;
		entry_value <= t.val;
		point_x <= t.x;
		point_y <= t.y;
		point_z <= t.z;
		do @(posedge clk); while (!in_ready);
		gap = use_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load(int idx, longint val);
		xact_t t;
		t = '0;
		t.cmd = CMD_LOAD;
		t.idx = IDX_W'(idx);
		t.val = FIELD_W'(val);
		send(t, 1);
	endtask

	task automatic point(longint x, longint y, longint z);
		xact_t t;
		t = '0;
		t.idx = IDX_W'($urandom());
		t.val = $urandom();
		t.cmd = CMD_PROJECT;
		t.x = FIELD_W'(x);
		t.y = FIELD_W'(y);
		t.z = FIELD_W'(z);
		send(t, 1);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_screen(int w, int h);
		drain();
		cfg_valid <= 1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= SIZE_W'(w);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= SIZE_W'(h);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic int small_q(int half);
		return int'($urandom_range(0, 2 * half)) - half;
	endfunction

	task automatic load_scene();
		for (int i = 0; i < 32; i++) begin
			case (i)
				3, 7, 11: load(i, 0);
				15: load(i, ONE);
				19, 23, 27: load(i, small_q(16384));
				31: load(i, $urandom_range(4 * 65536, 16 * 65536));
				default: load(i, small_q(131072));
			endcase
		end
	endtask

	task automatic random_phase(int n);
		int r;
		load_scene();
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 19);
			if (r < 14)
				point(small_q(1 << 20), small_q(1 << 20), small_q(1 << 20));
			else if (r < 16)
				point($urandom(), $urandom(), $urandom());
			else if (r < 18)
				load($urandom_range(0, 31), small_q(131072));
			else
				load($urandom_range(0, 31), $urandom());
		end
	endtask

	initial begin
		in_valid = 0;
		cmd = CMD_LOAD;
		entry_index = '0;
		entry_value = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		cfg_valid = 0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);

		point(65536, 65536, 65536);
		load(0, ONE);
		load(5, ONE);
		load(10, ONE);
		load(15, ONE);
		load(16, ONE);
		load(21, ONE);
		load(26, ONE);
		load(31, ONE);
		point(0, 0, 0);
		point(ONE, -ONE, 0);
		point(32'h7fffffff, 32'h80000000, 0);
		point(0, 0, -2 * ONE);
		point(0, 0, 32'h7fffffff);
		load(31, 1);
		point(0, 0, 0);
		load(31, 2);
		point(1, -1, 0);
		load(31, 0);
		point(0, 0, 0);
		load(0, 32'h7fffffff);
		load(31, ONE);
		point(32'h7fffffff, 0, 0);
		load(0, ONE);

		random_phase(120);
		set_screen(1, 1);
		random_phase(120);
		set_screen(32767, 32767);
		random_phase(120);
		set_screen(0, 16384);
		random_phase(120);
		stall_out = 0;
		set_screen($urandom_range(1, 32767), $urandom_range(1, 32767));
		random_phase(80);
		stall_out = 1;
		random_phase(80);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
